>>> src/adpcm_pkg.sv
// ----------------------------------------------------------------------------
// adpcm_pkg
// Shared types and constants of the ADPCM frame decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package adpcm_pkg;

   localparam int PREDICTOR_COUNT = 8;
   localparam int BOOK_WORDS      = PREDICTOR_COUNT * 16;
   localparam int BOOK_AW         = $clog2(BOOK_WORDS);
   localparam int Q_SHIFT         = 11;
   localparam int FQ_DEPTH        = 2;
   localparam int CSR_IDX_W       = 1;

   localparam logic [1:0] OP_BOOK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_BYTE  = 2'd2;

   localparam logic [1:0] MODE_ZERO = 2'd0;
   localparam logic [1:0] MODE_LOOP = 2'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_OLDER = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_NEWER = 1'b1;

   typedef struct packed {
      logic [1:0]         operation;
      logic [6:0]         book_address;
      logic signed [15:0] book_value;
      logic [1:0]         start_mode;
      logic [7:0]         stream_byte;
   } req_type;

   typedef struct packed {
      logic signed [15:0] first_sample;
      logic signed [15:0] second_sample;
      logic               frame_done;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_BOOK,
      CMD_START,
      CMD_BYTE
   } cmd_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [6:0]         book_address;
      logic signed [15:0] book_value;
      logic [1:0]         start_mode;
      logic [7:0]         stream_byte;
   } qitem_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_SAMPLE
   } back_state_type;

endpackage
`default_nettype wire

>>> src/adpcm_front.sv
// ----------------------------------------------------------------------------
// adpcm_front
// Accepts request words, drops unused operations and queues the rest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module adpcm_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire adpcm_pkg::req_type    req_item,
   output logic                       q_valid,
   output adpcm_pkg::qitem_type       q_item,
   input  wire logic                  q_pop
);
   import adpcm_pkg::*;

   localparam int PW = $clog2(FQ_DEPTH);
   localparam int CW = $clog2(FQ_DEPTH + 1);

   qitem_type        ent_ff [FQ_DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   qitem_type        cls;
   logic             keep, push_ok, do_wr;

   always_comb begin
      cls.book_address = req_item.book_address;
      cls.book_value   = req_item.book_value;
      cls.start_mode   = req_item.start_mode;
      cls.stream_byte  = req_item.stream_byte;
      keep             = 1'b1;
      unique case (req_item.operation)
         OP_BOOK:  cls.cmd = CMD_BOOK;
         OP_START: cls.cmd = CMD_START;
         OP_BYTE:  cls.cmd = CMD_BYTE;
         default: begin
            cls.cmd = CMD_BOOK;
            keep    = 1'b0;
         end
      endcase
   end

   assign req_full = (cnt_ff == CW'(FQ_DEPTH));
   assign push_ok  = req_push && !req_full;
   assign do_wr    = push_ok && keep;
   assign q_valid  = (cnt_ff != '0);
   assign q_item   = ent_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_wr) begin
         wr_in = (wr_ff == PW'(FQ_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_in = (rd_ff == PW'(FQ_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_wr && !q_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!do_wr && q_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         ent_ff[wr_ff] <= cls;
      end
   end

endmodule
`default_nettype wire

>>> src/adpcm_back.sv
// ----------------------------------------------------------------------------
// adpcm_back
// Codebook memory, frame state and the shared multiply-accumulate sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module adpcm_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   input  wire adpcm_pkg::qitem_type  q_item,
   output logic                       q_pop,
   input  wire logic signed [15:0]    loop_older,
   input  wire logic signed [15:0]    loop_newer,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output adpcm_pkg::rsp_type         rsp_item
);
   import adpcm_pkg::*;

   back_state_type     state_ff, state_in;
   logic [3:0]         pos_ff, scale_ff;
   logic [2:0]         psel_ff;
   logic signed [15:0] hist_old_ff, hist_new_ff;
   logic signed [15:0] res_ff [8];
   logic [2:0]         grp_ff, samp_ff;
   logic [3:0]         tap_ff, rd_tap_ff;
   logic               rd_vld_ff, prod_vld_ff;
   logic signed [15:0] rdata_ff;
   logic signed [31:0] prod_ff;
   logic [31:0]        acc_ff;
   logic signed [15:0] s0_ff;
   logic               out_valid_ff;
   rsp_type            out_ff;
   logic signed [15:0] book_mem [BOOK_WORDS];

   logic               issuing, drained, first_pass, done;
   logic [BOOK_AW-1:0] rd_addr;
   logic               row;
   logic [2:0]         col, jj;
   logic signed [15:0] operand, res_hi, res_lo;
   logic signed [15:0] sample;
   logic [31:0]        acc_in;

   function automatic logic signed [15:0] make_res(input logic [3:0] nib,
                                                   input logic [3:0] sh);
      logic signed [15:0] w;
      w = {{12{nib[3]}}, nib};
      return w <<< sh;
   endfunction

   // pop when the item can be finished; data bytes need a free result slot
   assign q_pop = (state_ff == ST_IDLE) && q_valid &&
                  (q_item.cmd != CMD_BYTE || pos_ff == 4'd0 || !out_valid_ff);

   assign jj     = {pos_ff[1:0] - 2'd1, 1'b0};
   assign res_hi = make_res(q_item.stream_byte[7:4], scale_ff);
   assign res_lo = make_res(q_item.stream_byte[3:0], scale_ff);

   assign issuing    = (state_ff == ST_MAC) && ({1'b0, tap_ff} < ({2'b0, samp_ff} + 5'd2));
   assign drained    = !issuing && !rd_vld_ff && !prod_vld_ff;
   assign first_pass = (samp_ff == grp_ff);
   assign done       = (pos_ff >= 4'd8);

   // term 0 uses row 0, every later term row 1; residual taps walk backward
   assign row = (tap_ff != 4'd0);
   assign col = (tap_ff <= 4'd1) ? samp_ff : samp_ff - tap_ff[2:0] + 3'd1;
   assign rd_addr = BOOK_AW'(int'(psel_ff) * 16 + int'(row) * 8 + int'(col));

   always_comb begin
      unique case (rd_tap_ff)
         4'd0:    operand = hist_old_ff;
         4'd1:    operand = hist_new_ff;
         default: operand = res_ff[3'(rd_tap_ff - 4'd2)];
      endcase
   end

   // arithmetic shift by 11 then clamp to 16 bits
   always_comb begin
      if (!acc_ff[31] && acc_ff[30:26] != 5'b0) begin
         sample = 16'sh7fff;
      end else if (acc_ff[31] && acc_ff[30:26] != 5'b11111) begin
         sample = -16'sh8000;
      end else begin
         sample = acc_ff[26:11];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop && q_item.cmd == CMD_BYTE && pos_ff != 4'd0) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (drained) begin
               state_in = ST_SAMPLE;
            end
         end
         ST_SAMPLE: begin
            state_in = first_pass ? ST_MAC : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      if (state_ff == ST_IDLE) begin
         acc_in = 32'(res_hi) << Q_SHIFT;
      end else if (state_ff == ST_SAMPLE) begin
         acc_in = 32'(res_ff[grp_ff + 3'd1]) << Q_SHIFT;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         scale_ff     <= '0;
         psel_ff      <= '0;
         hist_old_ff  <= '0;
         hist_new_ff  <= '0;
         res_ff       <= '{default: '0};
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_vld_ff   <= issuing;
         prod_vld_ff <= rd_vld_ff;
         if (rsp_pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
         if (q_pop) begin
            unique case (q_item.cmd)
               CMD_START: begin
                  if (q_item.start_mode == MODE_ZERO) begin
                     hist_old_ff <= '0;
                     hist_new_ff <= '0;
                  end else if (q_item.start_mode == MODE_LOOP) begin
                     hist_old_ff <= loop_older;
                     hist_new_ff <= loop_newer;
                  end
                  pos_ff <= '0;
                  res_ff <= '{default: '0};
               end
               CMD_BYTE: begin
                  if (pos_ff == 4'd0) begin
                     scale_ff <= q_item.stream_byte[7:4];
                     psel_ff  <= 3'(q_item.stream_byte[2:0] % PREDICTOR_COUNT);
                     pos_ff   <= 4'd1;
                  end else begin
                     res_ff[jj]        <= res_hi;
                     res_ff[jj + 3'd1] <= res_lo;
                  end
               end
               default: ;
            endcase
         end
         if (state_ff == ST_SAMPLE && !first_pass) begin
            out_valid_ff <= 1'b1;
            if (grp_ff == 3'd6) begin
               hist_old_ff <= s0_ff;
               hist_new_ff <= sample;
            end
            pos_ff <= done ? 4'd0 : pos_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      rdata_ff  <= book_mem[rd_addr];
      rd_tap_ff <= tap_ff;
      prod_ff   <= rdata_ff * operand;
      if (q_pop && q_item.cmd == CMD_BOOK && int'(q_item.book_address) < BOOK_WORDS) begin
         book_mem[BOOK_AW'(q_item.book_address)] <= q_item.book_value;
      end
      if (state_ff == ST_IDLE) begin
         grp_ff  <= jj;
         samp_ff <= jj;
         tap_ff  <= '0;
      end else if (state_ff == ST_SAMPLE) begin
         s0_ff   <= sample;
         samp_ff <= grp_ff + 3'd1;
         tap_ff  <= '0;
      end else if (issuing) begin
         tap_ff <= tap_ff + 4'd1;
      end
      if (state_ff == ST_SAMPLE && !first_pass) begin
         out_ff.first_sample  <= s0_ff;
         out_ff.second_sample <= sample;
         out_ff.frame_done    <= done;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_ff;

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE) else $error("queue popped while busy");
   a_busy_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> pos_ff != 4'd0) else $error("mac without data byte");
   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SAMPLE && !first_pass |-> !out_valid_ff)
      else $error("result slot overwritten");
   a_sample_pair: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MAC |-> samp_ff == grp_ff || samp_ff == grp_ff + 3'd1)
      else $error("sample index out of group");

endmodule
`default_nettype wire

>>> src/adpcm_frame_decoder.sv
// path: a word passes through the input queue; a codebook word, start word or
// header byte takes effect when popped; a data byte runs the MAC sequencer, the
// later in its group the longer: one product per cycle on the shared multiplier
// capacity: one word in flight in the back end; two words queue at the input
// reset: synchronous, clears history, frame state and queues; codebook not cleared
// ----------------------------------------------------------------------------
// adpcm_frame_decoder
// Second-order ADPCM frame decoder with a queued front end and a MAC back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module adpcm_frame_decoder (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire adpcm_pkg::req_type                  req_item,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output adpcm_pkg::rsp_type                       rsp_item,
   input  wire logic                                csr_we,
   input  wire logic [adpcm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [15:0]                         csr_data
);
   import adpcm_pkg::*;

   logic signed [15:0] loop_older_ff, loop_newer_ff;
   logic               q_valid, q_pop;
   qitem_type          q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_older_ff <= '0;
         loop_newer_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOOP_OLDER: loop_older_ff <= csr_data;
            CSR_LOOP_NEWER: loop_newer_ff <= csr_data;
            default: ;
         endcase
      end
   end

   adpcm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   adpcm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .loop_older (loop_older_ff),
      .loop_newer (loop_newer_ff),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_item   (rsp_item)
   );

endmodule
`default_nettype wire
